@@ design/kdlp_pkg.sv @@
package kdlp_pkg;

  localparam int NUM_KEYS   = 8;
  localparam int KEY_W      = 3;
  localparam int DEB_W      = 7;
  localparam int TICK_W     = 16;
  localparam int CNT_W      = 17;
  localparam int FILT_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int S_DATA_W   = 8;
  localparam int M_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd2;

  typedef enum logic [1:0] {
    ST_UNKNOWN = 2'd0,
    ST_ACTIVE  = 2'd1,
    ST_IDLE    = 2'd2
  } deb_state_t;

  typedef struct packed {
    logic signed [FILT_W-1:0] filter;
    deb_state_t               state;
    logic [CNT_W-1:0]         hold;
    logic [CNT_W-1:0]         rpt;
  } key_state_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ticks;
    logic [TICK_W-1:0] hold_ticks;
    logic [TICK_W-1:0] repeat_ticks;
  } cfg_t;

  // The last member lands in the lowest bit.
  typedef struct packed {
    logic released_flag;
    logic release_flag;
    logic long_release_flag;
    logic repeat_flag;
    logic long_press_flag;
    logic pressed_flag;
    logic press_flag;
  } flags_t;

endpackage

@@ design/kdlp_cfg_regs.sv @@
module kdlp_cfg_regs
  import kdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEB_W'(5);
      cfg.hold_ticks     <= TICK_W'(100);
      cfg.repeat_ticks   <= TICK_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg.debounce_ticks <= cfg_wdata[DEB_W-1:0];
        REG_HOLD:     cfg.hold_ticks     <= cfg_wdata[TICK_W-1:0];
        REG_REPEAT:   cfg.repeat_ticks   <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/kdlp_key_logic.sv @@
module kdlp_key_logic
  import kdlp_pkg::*;
(
  input  cfg_t       cfg,
  input  key_state_t cur_st,
  input  logic       level,
  output key_state_t nxt_st,
  output flags_t     flags
);

  always_comb begin
    logic signed [FILT_W:0] f_ext;
    logic signed [FILT_W:0] bound_pos;
    logic signed [FILT_W:0] bound_neg;
    logic signed [FILT_W:0] f_step;
    deb_state_t             st;
    logic [CNT_W-1:0]       hold_lim;
    logic [CNT_W:0]         rpt_inc;

    f_ext     = {cur_st.filter[FILT_W-1], cur_st.filter};
    bound_pos = signed'({2'b00, cfg.debounce_ticks});
    bound_neg = -bound_pos;
    f_step    = f_ext;
    st        = cur_st.state;
    hold_lim  = {1'b0, cfg.hold_ticks};
    rpt_inc   = '0;
    flags     = '0;

    // The filter saturates at the bound and switches state on reaching it.
    if (level) begin
      if (f_ext < bound_pos) begin
        f_step = f_ext + 9'sd1;
        if (f_step == bound_pos) begin
          st = ST_ACTIVE;
        end
      end
    end else begin
      if (f_ext > bound_neg) begin
        f_step = f_ext - 9'sd1;
        if (f_step == bound_neg) begin
          st = ST_IDLE;
        end
      end
    end

    nxt_st        = cur_st;
    nxt_st.filter = f_step[FILT_W-1:0];
    nxt_st.state  = st;

    if (st == ST_ACTIVE && cur_st.state != ST_ACTIVE) begin
      flags.press_flag = 1'b1;
      nxt_st.hold      = '0;
      nxt_st.rpt       = '0;
    end

    if (st == ST_ACTIVE) begin
      flags.pressed_flag = 1'b1;
      if (nxt_st.hold < hold_lim) begin
        nxt_st.hold = nxt_st.hold + 17'd1;
      end else begin
        if (nxt_st.hold == hold_lim) begin
          flags.long_press_flag = 1'b1;
          nxt_st.hold           = nxt_st.hold + 17'd1;
        end
        rpt_inc = {1'b0, nxt_st.rpt} + 18'd1;
        if (rpt_inc > {2'b00, cfg.repeat_ticks}) begin
          flags.repeat_flag = 1'b1;
          nxt_st.rpt        = '0;
        end else begin
          nxt_st.rpt = rpt_inc[CNT_W-1:0];
        end
      end
    end

    if (st == ST_IDLE && cur_st.state != ST_IDLE) begin
      flags.long_release_flag = (cur_st.hold > hold_lim);
      flags.release_flag      = 1'b1;
      nxt_st.hold             = '0;
      nxt_st.rpt              = '0;
    end

    flags.released_flag = (st == ST_IDLE);
  end

endmodule

@@ design/key_debounce_long_press_repeat_top.sv @@
// Debounced keys with long press and autorepeat for up to eight keys.
// The input stream carries one poll tick per word: the key index and the
// sampled raw level of that key. Every accepted word yields exactly one
// output word with the key index and seven event flags for that tick.
// Each key keeps its own integrating filter, debounced state and hold and
// repeat counters in flip-flops; the debounce, hold and repeat settings are
// shared; the user must have them written through the plain configuration
// port only while idle; the block does not enforce this. A word passes an
// input register and then the per-key update logic into the output
// register. One word is accepted every cycle while m_tready stays high,
// also for the same key back to back, since the key state is updated at
// the edge that loads the output. With m_tready held low, both stages hold
// and s_tready drops only once the input register is full as well.
// Reset empties both stages, loads the default settings and clears every
// key to an unknown debounced state with a centered filter.
module key_debounce_long_press_repeat_top
  import kdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // key_index [2:0], raw_level [3], zero fill above.
  input  logic [S_DATA_W-1:0]   s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // key_id [2:0], press_flag [3], pressed_flag [4], long_press_flag [5],
  // repeat_flag [6], long_release_flag [7], release_flag [8],
  // released_flag [9], zero fill above.
  output logic [M_DATA_W-1:0]   m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int FLAGS_W = $bits(flags_t);

  cfg_t             cfg;
  logic             in_valid;
  logic [KEY_W-1:0] in_key;
  logic             in_level;
  logic             advance;
  logic             in_range;
  key_state_t       key_st [NUM_KEYS];
  key_state_t       cur_st;
  key_state_t       nxt_st;
  flags_t           flags;
  flags_t           flags_sel;

  kdlp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign in_range = (32'(in_key) < NUM_KEYS);
  assign cur_st   = key_st[in_key];

  kdlp_key_logic u_key_logic (
    .cfg    (cfg),
    .cur_st (cur_st),
    .level  (in_level),
    .nxt_st (nxt_st),
    .flags  (flags)
  );

  assign flags_sel = in_range ? flags : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
      if (s_tvalid) begin
        in_key   <= s_tdata[KEY_W-1:0];
        in_level <= s_tdata[KEY_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        m_tdata <= {{(M_DATA_W-FLAGS_W-KEY_W){1'b0}}, flags_sel, in_key};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_st[k].filter <= '0;
        key_st[k].state  <= ST_UNKNOWN;
        key_st[k].hold   <= '0;
        key_st[k].rpt    <= '0;
      end
    end else if (advance && in_valid && in_range) begin
      key_st[in_key] <= nxt_st;
    end
  end

`ifndef SYNTHESIS
  a_press_implies_pressed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[3] || m_tdata[4]))
    else $error("press flag without pressed flag");

  a_pressed_released_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[4] && m_tdata[9]))
    else $error("pressed and released flags both set");

  a_long_release_implies_release: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[7] || m_tdata[8]))
    else $error("long release flag without release flag");

  a_input_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_key) && $stable(in_level)))
    else $error("input stage lost a word under stall");

  a_reset_empties_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import kdlp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic             level;
    logic [KEY_W-1:0] key;
  } poll_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    flags_t           flags;
  } key_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  key_debounce_long_press_repeat_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [DEB_W-1:0]  deb_ticks = 7'd5;
  logic [TICK_W-1:0] hold_ticks = 16'd100;
  logic [TICK_W-1:0] rpt_ticks = 16'd10;

  int               key_filter [NUM_KEYS];
  deb_state_t       key_state [NUM_KEYS];
  logic [CNT_W-1:0] key_hold [NUM_KEYS];
  logic [CNT_W-1:0] key_repeat [NUM_KEYS];

  poll_t       polls [$];
  key_report_t key_reports [$];
  poll_t       cur_poll;
  int          src_mode = 0;
  int          snk_mode = 0;
  int          src_gap = 0;
  int          snk_gap = 0;
  int          errors = 0;
  int unsigned cycles = 0;

  string flag_names [7] = '{"press_flag", "pressed_flag", "long_press_flag", "repeat_flag",
                            "long_release_flag", "release_flag", "released_flag"};

  function automatic key_report_t debounce_poll(poll_t p);
    key_report_t r;
    int k;
    int bound;
    deb_state_t prev;
    deb_state_t cur;
    r.key = p.key;
    r.flags = '0;
    k = p.key;
    bound = int'(deb_ticks);
    prev = key_state[k];
    cur = prev;
    if (p.level) begin
      if (key_filter[k] < bound) begin
        key_filter[k]++;
        if (key_filter[k] == bound) cur = ST_ACTIVE;
      end
    end else if (key_filter[k] > -bound) begin
      key_filter[k]--;
      if (key_filter[k] == -bound) cur = ST_IDLE;
    end
    if (cur == ST_ACTIVE && prev != ST_ACTIVE) begin
      r.flags.press_flag = 1'b1;
      key_hold[k] = '0;
      key_repeat[k] = '0;
    end
    if (cur == ST_ACTIVE) begin
      r.flags.pressed_flag = 1'b1;
      if (key_hold[k] < hold_ticks) begin
        key_hold[k]++;
      end else begin
        if (key_hold[k] == hold_ticks) begin
          r.flags.long_press_flag = 1'b1;
          key_hold[k]++;
        end
        key_repeat[k]++;
        if (key_repeat[k] > rpt_ticks) begin
          r.flags.repeat_flag = 1'b1;
          key_repeat[k] = '0;
        end
      end
    end
    if (cur == ST_IDLE && prev != ST_IDLE) begin
      if (key_hold[k] > hold_ticks) r.flags.long_release_flag = 1'b1;
      r.flags.release_flag = 1'b1;
      key_hold[k] = '0;
      key_repeat[k] = '0;
    end
    if (cur == ST_IDLE) r.flags.released_flag = 1'b1;
    key_state[k] = cur;
    return r;
  endfunction

  function automatic int draw_wait(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
      default: return $urandom_range(0, 14);
    endcase
  endfunction

  task automatic note_mismatch(string what, logic [M_DATA_W-1:0] want,
                               logic [M_DATA_W-1:0] seen);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %0h, got %0h", what, want, seen);
  endtask

  task automatic check_report(logic [M_DATA_W-1:0] word);
    key_report_t want;
    flags_t      got;
    if (key_reports.size() == 0) begin
      note_mismatch("unexpected word", '0, word);
      return;
    end
    want = key_reports.pop_front();
    got = flags_t'(word[KEY_W +: $bits(flags_t)]);
    if (word[KEY_W-1:0] !== want.key) begin
      note_mismatch("key_id", M_DATA_W'(want.key), M_DATA_W'(word[KEY_W-1:0]));
    end
    for (int i = 0; i < $bits(flags_t); i++) begin
      if (got[i] !== want.flags[i]) begin
        note_mismatch(flag_names[i], M_DATA_W'(want.flags[i]), M_DATA_W'(got[i]));
      end
    end
    if (word[M_DATA_W-1:KEY_W+$bits(flags_t)] !== '0) begin
      note_mismatch("zero fill", '0, M_DATA_W'(word[M_DATA_W-1:KEY_W+$bits(flags_t)]));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        key_reports.push_back(debounce_poll(cur_poll));
        src_gap = draw_wait(src_mode);
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0 || polls.size() == 0) begin
          s_tvalid <= 1'b0;
          if (src_gap > 0) src_gap--;
        end else begin
          cur_poll = polls.pop_front();
          s_tdata <= S_DATA_W'(cur_poll);
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_report(m_tdata);
        snk_gap = draw_wait(snk_mode);
      end
      if (snk_gap > 0) begin
        m_tready <= 1'b0;
        snk_gap--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE: deb_ticks = val[DEB_W-1:0];
      REG_HOLD:     hold_ticks = val;
      REG_REPEAT:   rpt_ticks = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] deb_word(logic [DEB_W-1:0] d);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom);
    w[DEB_W-1:0] = d;
    return w;
  endfunction

  task automatic set_regs(logic [DEB_W-1:0] d, logic [TICK_W-1:0] h, logic [TICK_W-1:0] r);
    write_reg(REG_DEBOUNCE, deb_word(d));
    write_reg(REG_HOLD, h);
    write_reg(REG_REPEAT, r);
  endtask

  task automatic add_poll(int k, bit lvl);
    poll_t p;
    p.key = KEY_W'(k);
    p.level = lvl;
    polls.push_back(p);
  endtask

  // Waits until every word has been sent and answered, then lets the pipeline empty.
  task automatic settle();
    while (polls.size() != 0 || s_tvalid || key_reports.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly steady runs of one key's level with some bounce and some polls of other
  // keys mixed in, the rest plain noise.
  task automatic fill_random(int target);
    int n;
    int len;
    int span;
    poll_t p;
    logic [KEY_W-1:0] k;
    logic lvl;
    n = 0;
    while (n < target) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          p.key = KEY_W'($urandom);
          p.level = 1'($urandom);
          polls.push_back(p);
        end
      end else begin
        k = KEY_W'($urandom);
        lvl = 1'($urandom);
        span = 2 * int'(deb_ticks) + int'(hold_ticks) + 3 * (int'(rpt_ticks) + 1) + 2;
        if (span > 120) span = 120;
        len = $urandom_range(1, span);
        repeat (len) begin
          p.key = k;
          p.level = lvl;
          if ($urandom_range(0, 15) == 0) p.level = ~lvl;
          if ($urandom_range(0, 7) == 0) p.key = KEY_W'($urandom);
          polls.push_back(p);
        end
      end
      n += len;
    end
  endtask

  initial begin
    logic [DEB_W-1:0]  d;
    logic [TICK_W-1:0] h;
    logic [TICK_W-1:0] r;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_filter[k] = 0;
      key_state[k] = ST_UNKNOWN;
      key_hold[k] = '0;
      key_repeat[k] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_mode = $urandom_range(0, 2);
    snk_mode = $urandom_range(0, 2);

    // Single-tick debounce with zero hold and zero repeat.
    set_regs(7'd1, 16'd0, 16'd0);
    add_poll(3, 1);
    add_poll(3, 1);
    add_poll(3, 0);
    add_poll(3, 0);
    add_poll(5, 0);
    add_poll(5, 1);
    add_poll(5, 1);
    add_poll(7, 1);
    settle();

    // A zero bound freezes filters that sit at zero.
    write_reg(REG_DEBOUNCE, deb_word(7'd0));
    write_reg(REG_NONE, CFG_DATA_W'($urandom));
    add_poll(3, 1);
    add_poll(3, 0);
    add_poll(7, 0);
    add_poll(0, 0);
    add_poll(0, 1);
    add_poll(7, 1);
    settle();

    // Lowering the bound below a filter that has already climbed past it.
    set_regs(7'd127, 16'hFFFF, 16'hFFFF);
    repeat (4) add_poll(1, 1);
    settle();
    write_reg(REG_DEBOUNCE, deb_word(7'd2));
    add_poll(1, 1);
    repeat (6) add_poll(1, 0);
    settle();

    // Long hold before the long press, then a repeat on every tick.
    src_mode = 0;
    snk_mode = 0;
    set_regs(7'd1, 16'd100, 16'd0);
    repeat (104) add_poll(2, 1);
    repeat (2) add_poll(2, 0);
    settle();

    // Long press at once, then a long repeat period.
    set_regs(7'd1, 16'd0, 16'd100);
    repeat (104) add_poll(4, 1);
    repeat (2) add_poll(4, 0);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 11))
        0: d = 7'd0;
        1: d = 7'd127;
        default: d = DEB_W'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0: h = 16'd0;
        1: h = 16'hFFFF;
        default: h = TICK_W'($urandom_range(0, 12));
      endcase
      case ($urandom_range(0, 9))
        0: r = 16'd0;
        1: r = 16'hFFFF;
        default: r = TICK_W'($urandom_range(0, 4));
      endcase
      set_regs(d, h, r);
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, CFG_DATA_W'($urandom));
      src_mode = $urandom_range(0, 2);
      snk_mode = $urandom_range(0, 2);
      fill_random(90);
      settle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
